>>> rtl/fel_pkg.sv
// Package for the frame energy level meter: item and frame types, sizes,
// and the fixed-point threshold tables. Depends on nothing.
package fel_pkg;

  // Largest number of samples counted in one frame.
  localparam int FRAME_MAX = 4096;
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);
  // A squared magnitude is at most 2^30.
  localparam int SQ_W      = 31;
  localparam int SUM_W     = SQ_W + $clog2(FRAME_MAX);
  // Sum scaled by up to 1000 (10 bits).
  localparam int LHS_W     = SUM_W + 10;
  localparam int TP_W      = 27;
  localparam int MUL_W     = CNT_W + TP_W;
  localparam int PROD_W    = MUL_W + 6;
  localparam int LEVEL_W   = 5;
  localparam int LEVEL_MAX = 30;
  localparam int Q_DEPTH   = 4;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
  localparam int SEARCH_STEPS = LEVEL_W;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               frame_too_long;
  } out_item_t;

  // One finished frame handed from the accumulator to the level search.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } frame_t;

  // Decade part of a level: 0 for 0..9, up to 3 for 30.
  function automatic logic [1:0] level_q(input logic [LEVEL_W-1:0] k);
    logic [1:0] r;
    if (k >= 5'd30) r = 2'd3;
    else if (k >= 5'd20) r = 2'd2;
    else if (k >= 5'd10) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

  // Step inside the decade: level modulo ten.
  function automatic logic [3:0] level_j(input logic [LEVEL_W-1:0] k);
    logic [LEVEL_W-1:0] r;
    if (k >= 5'd30) r = k - 5'd30;
    else if (k >= 5'd20) r = k - 5'd20;
    else if (k >= 5'd10) r = k - 5'd10;
    else r = k;
    return r[3:0];
  endfunction

  // round(2^24 * 10^(j/10)) for j = 0..9.
  function automatic logic [TP_W-1:0] tenth_pow(input logic [3:0] j);
    logic [TP_W-1:0] r;
    case (j)
      4'd0:    r = 27'd16777216;
      4'd1:    r = 27'd21121264;
      4'd2:    r = 27'd26590095;
      4'd3:    r = 27'd33474947;
      4'd4:    r = 27'd42142461;
      4'd5:    r = 27'd53054215;
      4'd6:    r = 27'd66791300;
      4'd7:    r = 27'd84085265;
      4'd8:    r = 27'd105857077;
      4'd9:    r = 27'd133266164;
      default: r = 27'd133266164;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/fel_front.sv
// Front end of the level meter: squares samples and accumulates each frame.
// Uses fel_pkg; hands finished frames to the frame queue.
module fel_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fel_pkg::in_item_t in_data,
  output logic             push,
  output fel_pkg::frame_t  push_data,
  input  logic             q_full
);
  import fel_pkg::*;

  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_last_r;
  logic [SQ_W-1:0] s1_sq_r;
  logic [16:0]     sx;
  logic [16:0]     mag;
  logic [33:0]     sq_full;

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_add;
  logic             ovf_r, ovf_nxt, ovf_add;
  logic             room;
  logic             s1_move;

  // A last sample waits in stage one while the queue has no room.
  assign in_stall = s1_valid_r && s1_last_r && q_full;
  assign s1_move  = s1_valid_r && !in_stall;

  // Magnitude and square of the incoming sample.
  always_comb begin
    sx      = {in_data.sample[15], in_data.sample};
    mag     = sx[16] ? (17'd0 - sx) : sx;
    sq_full = {17'd0, mag} * {17'd0, mag};
  end

  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sq_r   <= sq_full[SQ_W-1:0];
      s1_last_r <= in_data.last;
    end
  end

  // Accumulate while the frame has room, else only note the overflow.
  always_comb begin
    room    = cnt_r < CNT_W'(FRAME_MAX);
    sum_add = room ? (sum_r + SUM_W'(s1_sq_r)) : sum_r;
    cnt_add = room ? (cnt_r + CNT_W'(1)) : cnt_r;
    ovf_add = ovf_r | !room;

    push      = s1_move && s1_last_r;
    push_data = '{sum: sum_add, count: cnt_add, overflow: ovf_add};

    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (s1_move) begin
      if (s1_last_r) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_add;
        ovf_nxt = ovf_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

>>> rtl/fel_fifo.sv
// Short queue of finished frames between the accumulator and the search.
// Uses fel_pkg for the frame type and depth.
module fel_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fel_pkg::frame_t push_data,
  input  logic            pop,
  output fel_pkg::frame_t rd_data,
  output logic            full,
  output logic            empty
);
  import fel_pkg::*;

  frame_t            mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == QCNT_W'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  // Occupancy follows the push and pop of each cycle.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/fel_back.sv
// Back end of the level meter: scales each frame and finds its level by a
// pipelined bit-by-bit search, one threshold compare per stage. Uses fel_pkg.
module fel_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  fel_pkg::frame_t   q_rd_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fel_pkg::out_item_t out_data
);
  import fel_pkg::*;

  typedef struct packed {
    logic [3:0][LHS_W-1:0] lhs;
    logic [CNT_W-1:0]      n;
    logic                  zero;
    logic                  overflow;
    logic [LEVEL_W-1:0]    acc;
  } search_t;

  search_t                 stg_r [SEARCH_STEPS+1];
  logic [SEARCH_STEPS:0]   vld_r;
  logic                    adv;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // The whole pipeline holds while a result waits at the output.
  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !q_empty;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry stage: the sum times each decade factor, and the silent-frame flag.
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0].lhs[0]  <= LHS_W'(q_rd_data.sum) * LHS_W'(1000);
      stg_r[0].lhs[1]  <= LHS_W'(q_rd_data.sum) * LHS_W'(100);
      stg_r[0].lhs[2]  <= LHS_W'(q_rd_data.sum) * LHS_W'(10);
      stg_r[0].lhs[3]  <= LHS_W'(q_rd_data.sum);
      stg_r[0].n        <= q_rd_data.count;
      stg_r[0].zero     <= (q_rd_data.count == '0) || (q_rd_data.sum == '0);
      stg_r[0].overflow <= q_rd_data.overflow;
      stg_r[0].acc      <= '0;
    end
  end

  // Search stages: try the next level bit, keep it if its threshold is met.
  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
    localparam int B = SEARCH_STEPS - 1 - i;
    logic [LEVEL_W-1:0] cand;
    logic [1:0]         q;
    logic [MUL_W-1:0]   prod;
    logic [PROD_W-1:0]  rhs;
    logic               hit;

    always_comb begin
      cand = stg_r[i].acc | (LEVEL_W'(1) << B);
      q    = level_q(cand);
      prod = MUL_W'(stg_r[i].n) * MUL_W'(tenth_pow(level_j(cand)));
      rhs  = {prod, 6'd0};
      hit  = !stg_r[i].zero && (cand <= LEVEL_W'(LEVEL_MAX)) &&
             (stg_r[i].lhs[q] >= LHS_W'(rhs));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[i+1].lhs      <= stg_r[i].lhs;
        stg_r[i+1].n        <= stg_r[i].n;
        stg_r[i+1].zero     <= stg_r[i].zero;
        stg_r[i+1].overflow <= stg_r[i].overflow;
        stg_r[i+1].acc      <= hit ? cand : stg_r[i].acc;
      end
    end
  end

  // Valid bits of the stages and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[SEARCH_STEPS-1:0], !q_empty};
      out_valid_r <= vld_r[SEARCH_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.level          <= stg_r[SEARCH_STEPS].acc;
      out_data_r.frame_too_long <= stg_r[SEARCH_STEPS].overflow;
    end
  end

endmodule

>>> rtl/frame_energy_db_level_meter.sv
// Top level of the frame energy level meter: accumulator, frame queue and
// level search. Uses fel_pkg, fel_front, fel_fifo and fel_back.
//
// Use: PCM samples enter on the in_ channel, one per request, with last set
// on the final sample of a frame. For each last sample one result leaves on
// the out_ channel: the level 0..30 (30 plus the frame energy in dB relative
// to full scale, truncated, floored at 0) and a flag that the frame offered
// more than FRAME_MAX samples; samples past that count are dropped from the sum.
// Throughput: one sample per cycle while in_stall is low, also when every sample is a last one.
// The accumulator adds one square a cycle unless stalled, and the level search is
// a five stage pipeline, one threshold multiply-compare per stage.
// Path: the last sample of a frame passes the stage-one register, the frame queue,
// the entry stage, the search stages and the output register to out_valid.
// Stall: while out_stall holds a result, the search pipeline holds; up to
// four finished frames wait in the queue, and the input keeps taking samples
// until a last sample finds the queue full, then in_stall rises.
// Reset: synchronous rst_n clears the running frame, the queue and all valid
// bits; no result is pending after reset.
module frame_energy_db_level_meter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fel_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fel_pkg::out_item_t out_data
);
  import fel_pkg::*;

  logic   push, pop, q_full, q_empty;
  frame_t push_data, q_rd_data;

  fel_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  fel_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  fel_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_data (q_rd_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/fel_checker.sv
// Port-level checks for the frame energy level meter, bound to the top.
// Uses fel_pkg for the item types and the largest level.
module fel_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fel_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input fel_pkg::out_item_t out_data
);
  import fel_pkg::*;

  // A stalled request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed or vanished");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // The level never exceeds full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.level <= LEVEL_W'(LEVEL_MAX))
    else $error("level above full scale");

  // Reset leaves no pending result and an open input.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind frame_energy_db_level_meter fel_checker u_fel_checker (.*);

>>> test/frame_energy_db_level_meter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_energy_db_level_meter: sends PCM frames, predicts
// each frame's level and overlength flag, and checks every result in order.
// Depends on fel_pkg and the frame_energy_db_level_meter top level.

// Tracks the running frame and holds the results the block still owes.
class frame_level_checker;
  longint unsigned         energy_acc;
  int unsigned             accepted_cnt;
  bit                      too_long;
  fel_pkg::out_item_t      levels_due[$];
  int unsigned             mismatch_cnt;
  int unsigned             result_cnt;
  int unsigned             sample_total;
  int unsigned             overlong_frames;
  bit [fel_pkg::LEVEL_MAX:0] levels_seen;

  function new();
    energy_acc      = 0;
    accepted_cnt    = 0;
    too_long        = 1'b0;
    mismatch_cnt    = 0;
    result_cnt      = 0;
    sample_total    = 0;
    overlong_frames = 0;
    levels_seen     = '0;
  endfunction

  // Threshold steps inside one decade, 2^24 * 10^(j/10) rounded.
  static function longint unsigned step_ratio(int j);
    longint unsigned r;
    case (j)
      0:       r = 64'd16777216;
      1:       r = 64'd21121264;
      2:       r = 64'd26590095;
      3:       r = 64'd33474947;
      4:       r = 64'd42142461;
      5:       r = 64'd53054215;
      6:       r = 64'd66791300;
      7:       r = 64'd84085265;
      8:       r = 64'd105857077;
      default: r = 64'd133266164;
    endcase
    return r;
  endfunction

  // Largest level whose energy threshold the frame meets; silent or empty frames give 0.
  static function int frame_level(longint unsigned sum, int unsigned n);
    longint unsigned scaled;
    longint unsigned bar;
    longint unsigned gain;
    int k;
    k = 0;
    if (n != 0 && sum != 0) begin
      for (int t = fel_pkg::LEVEL_MAX; t >= 1; t--) begin
        case (t / 10)
          0:       gain = 1000;
          1:       gain = 100;
          2:       gain = 10;
          default: gain = 1;
        endcase
        scaled = sum * gain;
        bar    = longint'(n) * 64 * step_ratio(t % 10);
        if (k == 0 && scaled >= bar) begin
          k = t;
        end
      end
    end
    return k;
  endfunction

  function void count_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // An accepted request: add its square, or mark the frame as too long.
  function void note_request(fel_pkg::in_item_t req);
    longint            s;
    longint unsigned   mag;
    fel_pkg::out_item_t want;
    s   = req.sample;
    mag = (s < 0) ? -s : s;
    sample_total++;
    if (accepted_cnt < fel_pkg::FRAME_MAX) begin
      energy_acc += mag * mag;
      accepted_cnt++;
    end else begin
      too_long = 1'b1;
    end
    if (req.last) begin
      want.level          = fel_pkg::LEVEL_W'(frame_level(energy_acc, accepted_cnt));
      want.frame_too_long = too_long;
      levels_due = {levels_due, want};
      levels_seen[want.level] = 1'b1;
      if (too_long) begin
        overlong_frames++;
      end
      energy_acc   = 0;
      accepted_cnt = 0;
      too_long     = 1'b0;
    end
  endfunction

  // An accepted result: compare it field by field with the oldest prediction.
  function void check_result(fel_pkg::out_item_t got);
    fel_pkg::out_item_t want;
    result_cnt++;
    if (levels_due.size() == 0) begin
      count_error($sformatf("result %0d arrived with none expected: level %0d, too_long %0b",
                            result_cnt, got.level, got.frame_too_long));
      return;
    end
    want = levels_due.pop_front();
    if (got.level !== want.level) begin
      count_error($sformatf("result %0d level: expected %0d, got %0d",
                            result_cnt, want.level, got.level));
    end
    if (got.frame_too_long !== want.frame_too_long) begin
      count_error($sformatf("result %0d frame_too_long: expected %0b, got %0b",
                            result_cnt, want.frame_too_long, got.frame_too_long));
    end
  endfunction

  function int unsigned pending();
    return levels_due.size();
  endfunction
endclass

module frame_energy_db_level_meter_tb;
  import fel_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int IDLE_PCT       = 7;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_SAMPLES = 1830;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RUN_LIMIT_NS   = 5_000_000;
  localparam logic signed [15:0] PCM_MIN = 16'sh8000;
  localparam logic signed [15:0] PCM_MAX = 16'sh7fff;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  frame_level_checker levels;
  int in_idle_pct;
  int out_idle_pct;
  int hold_asked;

  frame_energy_db_level_meter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Both handshakes are sampled at the edge, with the values the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      levels.note_request(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      levels.check_result(out_data);
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : stall_driver
    int hold_left;
    int hold_given;
    hold_left  = 0;
    hold_given = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_given < hold_asked) begin
        hold_given++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Offer one request, after an optional random gap, and wait until it is taken.
  task automatic send_sample(input logic signed [15:0] s, input logic is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= '{sample: s, last: is_last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels.pending() != 0);
  endtask

  // One random frame: silent, full-scale extremes, or noise at a random amplitude.
  task automatic send_frame(input int len);
    int                 flavor;
    int                 shift;
    logic signed [15:0] s;
    flavor = $urandom_range(99);
    shift  = $urandom_range(15);
    for (int i = 0; i < len; i++) begin
      if (flavor < 5) begin
        s = '0;
      end else if (flavor < 10) begin
        s = $urandom_range(1) ? PCM_MIN : PCM_MAX;
      end else begin
        s = 16'($urandom);
        s = s >>> shift;
      end
      send_sample(s, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int sent;
    int frames;
    int len;
    levels       = new();
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    hold_asked   = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample frames at the extremes and around the bottom of the scale.
    send_sample(16'sd0, 1'b1);
    send_sample(PCM_MIN, 1'b1);
    send_sample(PCM_MAX, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1036, 1'b1);
    send_sample(16'sd1037, 1'b1);
    send_sample(-16'sd1162, 1'b1);
    send_sample(16'sd1163, 1'b1);
    // A short mixed frame, a half-scale frame and a silent frame.
    send_sample(PCM_MIN, 1'b0);
    send_sample(PCM_MAX, 1'b0);
    send_sample(16'sh1234, 1'b1);
    send_sample(16'sh4000, 1'b0);
    send_sample(-16'sh4000, 1'b0);
    send_sample(16'sd0, 1'b1);
    repeat (4) send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    wait_drained();

    // Random frames, mostly short so that last samples come often.
    sent   = 0;
    frames = 0;
    while (sent < RANDOM_SAMPLES) begin
      if (frames == 30) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (frames == 60) begin
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
      end
      // The receiver holds off while short frames keep coming, so the queue fills.
      if (frames == 80) begin
        hold_asked++;
      end
      if (frames == 120) begin
        wait_drained();
      end
      case ($urandom_range(9))
        0, 1, 2: len = 1;
        3:       len = $urandom_range(25, 64);
        default: len = $urandom_range(2, 24);
      endcase
      send_frame(len);
      sent += len;
      frames++;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d samples; %0d frames were over length.",
             levels.result_cnt, levels.sample_total, levels.overlong_frames);
    $display("Levels reached: %0d of %0d; mismatches: %0d; results still owed: %0d.",
             $countones(levels.levels_seen), LEVEL_MAX + 1, levels.mismatch_cnt,
             levels.pending());
    if (levels.mismatch_cnt == 0 && levels.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results still owed.", levels.pending());
    $display("status: fail");
    $finish;
  end
endmodule
